/* hdl/edid_pkg.sv */
// ----------------------------------------------------------------------------
// edid_pkg
// shared constants, command and snapshot types for the edid base block parser
// ----------------------------------------------------------------------------
`default_nettype none

package edid_pkg;

    // block geometry
    localparam int BLOCK_BYTES   = 128;
    localparam int STRING_BYTES  = 13;
    localparam int DESC_LEN      = 18;
    localparam int CMD_DEPTH_DEF = 8;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // result kinds
    localparam logic [4:0] KIND_VALID    = 5'd0;
    localparam logic [4:0] KIND_PNP      = 5'd1;
    localparam logic [4:0] KIND_SERIAL   = 5'd2;
    localparam logic [4:0] KIND_WIDTH    = 5'd3;
    localparam logic [4:0] KIND_HEIGHT   = 5'd4;
    localparam logic [4:0] KIND_GAMMA    = 5'd5;
    localparam logic [4:0] KIND_CHROMA   = 5'd6;
    localparam logic [4:0] KIND_STR_BASE = 5'd13;

    // summary item indexes
    localparam logic [3:0] SUM_VALID  = 4'd0;
    localparam logic [3:0] SUM_PNP    = 4'd1;
    localparam logic [3:0] SUM_SERIAL = 4'd2;
    localparam logic [3:0] SUM_WIDTH  = 4'd3;
    localparam logic [3:0] SUM_HEIGHT = 4'd4;
    localparam logic [3:0] SUM_GAMMA  = 4'd5;
    localparam logic [3:0] SUM_CHROMA = 4'd6;
    localparam logic [3:0] SUM_LAST   = 4'd13;

    // string descriptor kind
    typedef enum logic [1:0] {
        STR_NONE,
        STR_NAME,
        STR_SERIAL,
        STR_ALNUM
    } str_kind_t;

    // work for the back end, one per input byte that has results
    typedef struct packed {
        str_kind_t  str_kind;
        logic       sp;
        logic       ch_en;
        logic [7:0] ch;
        logic       term;
        logic       summ;
        logic       short_fin;
    } edid_cmd_t;

    // block data captured for the summary
    typedef struct packed {
        logic            hg;
        logic [15:0]     pnp;
        logic [31:0]     serial;
        logic [15:0]     size;
        logic [7:0]      gamma;
        logic [15:0]     clo;
        logic [7:0][7:0] chi;
    } edid_snap_t;

endpackage

`default_nettype wire

/* hdl/edid_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// edid_cmd_fifo
// short command queue between the byte front end and the result back end
// ----------------------------------------------------------------------------
`default_nettype none

module edid_cmd_fifo #(
    parameter int DEPTH = edid_pkg::CMD_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  edid_pkg::edid_cmd_t      din,
    input  wire logic                pop,
    output edid_pkg::edid_cmd_t      dout,
    output logic                     full,
    output logic                     empty
);
    import edid_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    edid_cmd_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // queue checks
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("command queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("command queue underflow");

endmodule

`default_nettype wire

/* hdl/edid_front.sv */
// ----------------------------------------------------------------------------
// edid_front
// accepts edid bytes, latches block fields, decodes descriptors into commands
// ----------------------------------------------------------------------------
`default_nettype none

module edid_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,    // byte_value[7:0]
    input  wire logic                s_tlast,    // last_byte
    input  wire logic                fifo_full,
    output logic                     fifo_push,
    output edid_pkg::edid_cmd_t      fifo_din,
    input  wire logic                snap_busy,
    output logic                     snap_load,
    output edid_pkg::edid_snap_t     snap_din
);
    import edid_pkg::*;

    // byte positions within the base block
    localparam logic [7:0] POS_HDR0      = 8'h00;
    localparam logic [7:0] POS_HDR1      = 8'h01;
    localparam logic [7:0] POS_PNP_HI    = 8'h08;
    localparam logic [7:0] POS_PNP_LO    = 8'h09;
    localparam logic [7:0] POS_SERIAL0   = 8'h0c;
    localparam logic [7:0] POS_SERIAL3   = 8'h0f;
    localparam logic [7:0] POS_WIDTH     = 8'h15;
    localparam logic [7:0] POS_HEIGHT    = 8'h16;
    localparam logic [7:0] POS_GAMMA     = 8'h17;
    localparam logic [7:0] POS_CHROMA_A  = 8'h19;
    localparam logic [7:0] POS_CHROMA_B  = 8'h1a;
    localparam logic [7:0] POS_CHROMA_HI = 8'h1b;
    localparam logic [7:0] POS_CHROMA_HE = 8'h22;
    localparam logic [7:0] DESC_FIRST    = 8'h36;
    localparam logic [7:0] DESC_END      = 8'h6c + 8'(DESC_LEN);
    localparam logic [7:0] POS_FINAL     = 8'(BLOCK_BYTES - 1);
    localparam logic [7:0] POS_DONE      = 8'(BLOCK_BYTES);

    // descriptor offsets
    localparam logic [4:0] OFF_TAG0      = 5'd0;
    localparam logic [4:0] OFF_TAG2      = 5'd2;
    localparam logic [4:0] OFF_TYPE      = 5'd3;
    localparam logic [4:0] OFF_STR_FIRST = 5'd5;
    localparam logic [4:0] OFF_STR_LAST  = 5'(4 + STRING_BYTES);
    localparam logic [4:0] OFF_WP_GAMMA1 = 5'd12;
    localparam logic [4:0] OFF_WP_GAMMA2 = 5'd17;
    localparam logic [4:0] OFF_WRAP      = 5'(DESC_LEN - 1);

    // descriptor tags
    localparam logic [7:0] TAG_NAME   = 8'hfc;
    localparam logic [7:0] TAG_SERIAL = 8'hff;
    localparam logic [7:0] TAG_ALNUM  = 8'hfe;
    localparam logic [7:0] TAG_CPOINT = 8'hfb;
    localparam logic [7:0] GAMMA_NONE = 8'hff;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2d;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c >= 8'h09 && c <= 8'h0d) || c == CHAR_SPACE || c == 8'h85 || c == 8'ha0;
    endfunction

    function automatic logic is_printable(input logic [7:0] c);
        is_printable = !(c < 8'h20 || (c >= 8'h7f && c <= 8'h9f) || c == 8'had);
    endfunction

    logic [7:0]  pos_reg, pos_next;
    logic        hg_reg, hg_next;
    logic [15:0] pnp_reg, pnp_next;
    logic [31:0] serial_reg, serial_next;
    logic [15:0] size_reg, size_next;
    logic [7:0]  gamma_reg, gamma_next;
    logic [15:0] clo_reg, clo_next;
    logic [7:0]  chi_reg [8];
    logic [4:0]  off_reg, off_next;
    logic        qual_reg, qual_next;
    str_kind_t   skind_reg, skind_next;
    logic        cpoint_reg, cpoint_next;
    logic        emitted_reg, emitted_next;
    logic        spc_reg, spc_next;

    logic        accept;
    logic        in_block;
    logic        in_desc;
    logic [7:0]  serial_off;
    logic [7:0]  chi_off;
    logic [7:0]  b;
    edid_cmd_t   cmd;

    assign s_tready   = !fifo_full && !(pos_reg == POS_FINAL && snap_busy);
    assign accept     = s_tvalid && s_tready;
    assign b          = s_tdata;
    assign in_block   = (pos_reg < POS_DONE);
    assign in_desc    = (pos_reg >= DESC_FIRST) && (pos_reg < DESC_END);
    assign serial_off = pos_reg - POS_SERIAL0;
    assign chi_off    = pos_reg - POS_CHROMA_HI;

    // byte decode and state update
    always_comb
    begin
        pos_next     = pos_reg;
        hg_next      = hg_reg;
        pnp_next     = pnp_reg;
        serial_next  = serial_reg;
        size_next    = size_reg;
        gamma_next   = gamma_reg;
        clo_next     = clo_reg;
        off_next     = off_reg;
        qual_next    = qual_reg;
        skind_next   = skind_reg;
        cpoint_next  = cpoint_reg;
        emitted_next = emitted_reg;
        spc_next     = spc_reg;
        cmd          = '0;
        cmd.str_kind = skind_reg;
        snap_load    = 1'b0;

        if (accept && in_block)
        begin
            priority if (pos_reg == POS_HDR0)
            begin
                hg_next = (b == 8'h00);
            end
            else if (pos_reg == POS_HDR1)
            begin
                hg_next = hg_reg && (b == 8'hff);
            end
            else if (pos_reg == POS_PNP_HI)
            begin
                pnp_next[15:8] = b;
            end
            else if (pos_reg == POS_PNP_LO)
            begin
                pnp_next[7:0] = b;
            end
            else if (pos_reg >= POS_SERIAL0 && pos_reg <= POS_SERIAL3)
            begin
                serial_next[{serial_off[1:0], 3'b000} +: 8] = b;
            end
            else if (pos_reg == POS_WIDTH)
            begin
                size_next[15:8] = b;
            end
            else if (pos_reg == POS_HEIGHT)
            begin
                size_next[7:0] = b;
            end
            else if (pos_reg == POS_GAMMA)
            begin
                gamma_next = b;
            end
            else if (pos_reg == POS_CHROMA_A)
            begin
                clo_next[15:8] = b;
            end
            else if (pos_reg == POS_CHROMA_B)
            begin
                clo_next[7:0] = b;
            end
            else if (in_desc)
            begin
                // descriptor walk
                off_next = (off_reg == OFF_WRAP) ? '0 : off_reg + 1'b1;
                if (off_reg == OFF_TAG0)
                begin
                    qual_next    = (b == 8'h00);
                    skind_next   = STR_NONE;
                    cpoint_next  = 1'b0;
                    emitted_next = 1'b0;
                    spc_next     = 1'b0;
                end
                else if (off_reg == OFF_TAG2)
                begin
                    if (b != 8'h00)
                    begin
                        qual_next    = 1'b0;
                        skind_next   = STR_NONE;
                        cpoint_next  = 1'b0;
                        emitted_next = 1'b0;
                        spc_next     = 1'b0;
                    end
                end
                else if (off_reg == OFF_TYPE)
                begin
                    if (qual_reg)
                    begin
                        if (b == TAG_NAME)
                        begin
                            skind_next = STR_NAME;
                        end
                        else if (b == TAG_SERIAL)
                        begin
                            skind_next = STR_SERIAL;
                        end
                        else if (b == TAG_ALNUM)
                        begin
                            skind_next = STR_ALNUM;
                        end
                        else if (b == TAG_CPOINT)
                        begin
                            cpoint_next = 1'b1;
                        end
                    end
                end
                else if (off_reg >= OFF_STR_FIRST && off_reg <= OFF_STR_LAST)
                begin
                    // color point gamma override
                    if (cpoint_reg && (off_reg == OFF_WP_GAMMA1 || off_reg == OFF_WP_GAMMA2)
                        && b != GAMMA_NONE)
                    begin
                        gamma_next = b;
                    end
                    // string characters with trim and collapse
                    if (skind_reg != STR_NONE && hg_reg)
                    begin
                        if (is_ws(b))
                        begin
                            if (emitted_reg)
                            begin
                                spc_next = 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.sp       = spc_reg;
                            spc_next     = 1'b0;
                            cmd.ch_en    = 1'b1;
                            cmd.ch       = is_printable(b) ? b : CHAR_DASH;
                            emitted_next = 1'b1;
                        end
                        if (off_reg == OFF_STR_LAST)
                        begin
                            cmd.term = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                // bytes with no field latched in this chain
            end

            if (pos_reg == POS_FINAL)
            begin
                cmd.summ  = 1'b1;
                snap_load = 1'b1;
            end
            pos_next = pos_reg + 1'b1;
        end

        // end of stream returns all state but the chromaticity high bytes to reset
        if (accept && s_tlast)
        begin
            cmd.short_fin = (pos_reg < POS_FINAL);
            pos_next      = '0;
            hg_next       = 1'b0;
            pnp_next      = '0;
            serial_next   = '0;
            size_next     = '0;
            gamma_next    = '0;
            clo_next      = '0;
            off_next      = '0;
            qual_next     = 1'b0;
            skind_next    = STR_NONE;
            cpoint_next   = 1'b0;
            emitted_next  = 1'b0;
            spc_next      = 1'b0;
        end
    end

    assign fifo_push = accept && (cmd.sp || cmd.ch_en || cmd.term || cmd.summ || cmd.short_fin);
    assign fifo_din  = cmd;

    // summary snapshot data
    always_comb
    begin
        snap_din.hg     = hg_reg;
        snap_din.pnp    = pnp_reg;
        snap_din.serial = serial_reg;
        snap_din.size   = size_reg;
        snap_din.gamma  = gamma_reg;
        snap_din.clo    = clo_reg;
        for (int i = 0; i < 8; i++)
        begin
            snap_din.chi[i] = chi_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            hg_reg      <= 1'b0;
            pnp_reg     <= '0;
            serial_reg  <= '0;
            size_reg    <= '0;
            gamma_reg   <= '0;
            clo_reg     <= '0;
            off_reg     <= '0;
            qual_reg    <= 1'b0;
            skind_reg   <= STR_NONE;
            cpoint_reg  <= 1'b0;
            emitted_reg <= 1'b0;
            spc_reg     <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            hg_reg      <= hg_next;
            pnp_reg     <= pnp_next;
            serial_reg  <= serial_next;
            size_reg    <= size_next;
            gamma_reg   <= gamma_next;
            clo_reg     <= clo_next;
            off_reg     <= off_next;
            qual_reg    <= qual_next;
            skind_reg   <= skind_next;
            cpoint_reg  <= cpoint_next;
            emitted_reg <= emitted_next;
            spc_reg     <= spc_next;
        end
    end

    // chromaticity high bytes
    always_ff @(posedge clk)
    begin
        if (accept && pos_reg >= POS_CHROMA_HI && pos_reg <= POS_CHROMA_HE)
        begin
            chi_reg[chi_off[2:0]] <= b;
        end
    end

    // position and descriptor offset bounds
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= POS_DONE)
        else $error("byte position beyond block end");
    assert property (@(posedge clk) disable iff (!rst_n) off_reg <= OFF_WRAP)
        else $error("descriptor offset out of range");

endmodule

`default_nettype wire

/* hdl/edid_back.sv */
// ----------------------------------------------------------------------------
// edid_back
// expands queued commands into result items behind an output register
// ----------------------------------------------------------------------------
`default_nettype none

module edid_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fifo_empty,
    input  edid_pkg::edid_cmd_t      fifo_dout,
    output logic                     fifo_pop,
    input  wire logic                snap_load,
    input  edid_pkg::edid_snap_t     snap_din,
    output logic                     snap_busy,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata,    // item_kind[4:0], item_value[36:5], zero[39:37]
    output logic                     m_tlast     // last
);
    import edid_pkg::*;

    localparam logic [31:0] CHAR_SPACE = 32'h20;
    localparam logic [7:0]  GAMMA_NONE = 8'hff;
    localparam logic [31:0] GAMMA_BASE = 32'd100;
    localparam logic [7:0]  PNP_BASE   = 8'h40;

    edid_cmd_t   cur_reg, cur_next;
    logic        cur_valid_reg, cur_valid_next;
    logic [3:0]  sum_idx_reg, sum_idx_next;
    edid_snap_t  snap_reg;
    logic        snap_busy_reg, snap_busy_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;

    logic        out_load;
    logic        item_last;
    logic        sum_done;
    logic [3:0]  sum_end;
    logic [4:0]  item_kind;
    logic [31:0] item_value;
    logic [4:0]  str_item_kind;
    edid_cmd_t   rest;
    logic [4:0]  sum_kind;
    logic [31:0] sum_value;
    logic [7:0]  b0, b1, w, h, c0, c1, c2;
    logic [2:0]  ck;
    logic [3:0]  lo_sh;
    logic [1:0]  lo;

    assign snap_busy = snap_busy_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign out_load      = cur_valid_reg && (!m_tvalid_reg || m_tready);
    assign str_item_kind = KIND_STR_BASE + {3'b000, cur_reg.str_kind};
    assign sum_end       = snap_reg.hg ? SUM_LAST : SUM_VALID;
    assign sum_done      = (sum_idx_reg == sum_end);

    // summary field formatting
    always_comb
    begin
        b0    = snap_reg.pnp[15:8];
        b1    = snap_reg.pnp[7:0];
        c0    = PNP_BASE + {3'b000, b0[6:2]};
        c1    = PNP_BASE + {3'b000, b0[1:0], b1[7:5]};
        c2    = PNP_BASE + {3'b000, b1[4:0]};
        w     = snap_reg.size[15:8];
        h     = snap_reg.size[7:0];
        if (w == 8'h00 || h == 8'h00)
        begin
            w = 8'h00;
            h = 8'h00;
        end
        ck    = 3'(sum_idx_reg - SUM_CHROMA);
        lo_sh = 4'd14 - {ck, 1'b0};
        lo    = snap_reg.clo[lo_sh +: 2];

        unique case (sum_idx_reg)
            SUM_VALID:
            begin
                sum_kind  = KIND_VALID;
                sum_value = {31'd0, snap_reg.hg};
            end
            SUM_PNP:
            begin
                sum_kind  = KIND_PNP;
                sum_value = {8'h00, c0, c1, c2};
            end
            SUM_SERIAL:
            begin
                sum_kind  = KIND_SERIAL;
                sum_value = snap_reg.serial;
            end
            SUM_WIDTH:
            begin
                sum_kind  = KIND_WIDTH;
                sum_value = {24'd0, w};
            end
            SUM_HEIGHT:
            begin
                sum_kind  = KIND_HEIGHT;
                sum_value = {24'd0, h};
            end
            SUM_GAMMA:
            begin
                sum_kind  = KIND_GAMMA;
                sum_value = (snap_reg.gamma == GAMMA_NONE) ? GAMMA_BASE
                          : GAMMA_BASE + {24'd0, snap_reg.gamma};
            end
            default:
            begin
                sum_kind  = KIND_CHROMA + {2'b00, ck};
                sum_value = {22'd0, snap_reg.chi[ck], lo};
            end
        endcase
    end

    // pick the next item of the current command
    always_comb
    begin
        rest       = cur_reg;
        item_kind  = str_item_kind;
        item_value = '0;
        priority if (cur_reg.sp)
        begin
            item_value = CHAR_SPACE;
            rest.sp    = 1'b0;
        end
        else if (cur_reg.ch_en)
        begin
            item_value = {24'd0, cur_reg.ch};
            rest.ch_en = 1'b0;
        end
        else if (cur_reg.term)
        begin
            rest.term = 1'b0;
        end
        else if (cur_reg.summ)
        begin
            item_kind  = sum_kind;
            item_value = sum_value;
            rest.summ  = !sum_done;
        end
        else
        begin
            item_kind      = KIND_VALID;
            rest.short_fin = 1'b0;
        end
        item_last = !(rest.sp || rest.ch_en || rest.term || rest.summ || rest.short_fin);
    end

    assign fifo_pop = !fifo_empty && (!cur_valid_reg || (out_load && item_last));

    // sequencer and output register
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        sum_idx_next   = sum_idx_reg;
        snap_busy_next = snap_busy_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, item_value, item_kind};
            m_tlast_next  = item_last;
            cur_next      = rest;
            if (item_last)
            begin
                cur_valid_next = 1'b0;
            end
            if (!cur_reg.sp && !cur_reg.ch_en && !cur_reg.term && cur_reg.summ)
            begin
                sum_idx_next = sum_done ? '0 : sum_idx_reg + 1'b1;
                if (sum_done)
                begin
                    snap_busy_next = 1'b0;
                end
            end
        end
        if (fifo_pop)
        begin
            cur_next       = fifo_dout;
            cur_valid_next = 1'b1;
        end
        if (snap_load)
        begin
            snap_busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sum_idx_reg   <= '0;
            snap_busy_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            sum_idx_reg   <= sum_idx_next;
            snap_busy_reg <= snap_busy_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (snap_load)
        begin
            snap_reg <= snap_din;
        end
    end

    // a held command always has work, a summary always has its snapshot
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.sp || cur_reg.ch_en || cur_reg.term
                           || cur_reg.summ || cur_reg.short_fin))
        else $error("empty command held");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && cur_reg.summ) |-> snap_busy_reg)
        else $error("summary without snapshot");

endmodule

`default_nettype wire

/* hdl/edid_base_block_parser_top.sv */
// ----------------------------------------------------------------------------
// edid_base_block_parser_top
// streaming edid 1.3 base block parser: strings and end-of-block summary
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tlast
//  s_*     | in  | byte_value[7:0]                    | last_byte
//  m_*     | out | item_kind[4:0], item_value[36:5]   | last result of a byte
//
//  one byte is accepted per cycle while the command queue has room
//  each byte yields 0 to 4 items, byte 127 a 14 item summary (1 item without a
//  good header); the output register sends one item per cycle while m_tready
//  is high, so string runs and the summary drain at that rate through the queue
//  byte 127 of a new block waits while the previous summary is still going out
//  rst_n clears position, latched fields but chi_reg, queue and output register
// ----------------------------------------------------------------------------
`default_nettype none

module edid_base_block_parser_top #(
    parameter int CMD_DEPTH = edid_pkg::CMD_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // byte_value[7:0]
    input  wire logic        s_tlast,    // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,    // item_kind[4:0], item_value[36:5], zero[39:37]
    output logic             m_tlast     // last
);
    import edid_pkg::*;

    logic       fifo_full;
    logic       fifo_empty;
    logic       fifo_push;
    logic       fifo_pop;
    edid_cmd_t  fifo_din;
    edid_cmd_t  fifo_dout;
    logic       snap_busy;
    logic       snap_load;
    edid_snap_t snap_din;

    // byte front end
    edid_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .fifo_push (fifo_push),
        .fifo_din  (fifo_din),
        .snap_busy (snap_busy),
        .snap_load (snap_load),
        .snap_din  (snap_din)
    );

    // command queue
    edid_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .din   (fifo_din),
        .pop   (fifo_pop),
        .dout  (fifo_dout),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    // result back end
    edid_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_dout  (fifo_dout),
        .fifo_pop   (fifo_pop),
        .snap_load  (snap_load),
        .snap_din   (snap_din),
        .snap_busy  (snap_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
